/* hw/rtl/median_then_exponential_smoother_core_macros.svh */
// Assertion helpers shared by the smoother RTL.
// Every macro samples on clk and is held off while rst_n is low.
`ifndef MEDIAN_THEN_EXPONENTIAL_SMOOTHER_CORE_MACROS_SVH
`define MEDIAN_THEN_EXPONENTIAL_SMOOTHER_CORE_MACROS_SVH

// Same-cycle implication
`define MTES_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define MTES_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/mtes_pkg.sv */
package mtes_pkg;

  // Window and sample geometry
  localparam int WINDOW      = 5;
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 8;
  localparam int WEIGHT_BITS = 8;
  localparam int WEIGHT_ONE  = 1 << FRAC_BITS;
  localparam int ACC_BITS    = SAMPLE_BITS + FRAC_BITS;
  localparam int PROD_BITS   = ACC_BITS + 2;
  localparam int AGE_BITS    = $clog2(WINDOW);
  localparam int CNT_BITS    = $clog2(WINDOW + 1);

  localparam logic [WEIGHT_BITS-1:0] WEIGHT_RESET = WEIGHT_BITS'(32);

  // One slot of the sorted chain
  typedef struct packed {
    logic                          valid;
    logic [AGE_BITS-1:0]           age;
    logic signed [SAMPLE_BITS-1:0] value;
  } cell_t;

  // Left edge of the chain: always present, never greater than a sample
  localparam cell_t CELL_LOW_EDGE = '{
    valid: 1'b1,
    age:   '0,
    value: {1'b1, {(SAMPLE_BITS-1){1'b0}}}
  };

  // Right edge of the chain: empty slot
  localparam cell_t CELL_EMPTY = '{valid: 1'b0, age: '0, value: '0};

  // Step controls for the smoother datapath
  typedef struct packed {
    logic load_med;
    logic mul;
    logic acc;
  } smooth_ctrl_t;

endpackage

/* hw/rtl/mtes_if.sv */
// Sample stream
interface mtes_sample_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [mtes_pkg::SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// Result stream
interface mtes_result_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [mtes_pkg::SAMPLE_BITS-1:0] smoothed;
  logic signed [mtes_pkg::SAMPLE_BITS-1:0] window_median;

  modport source (output valid, output smoothed, output window_median, input ready);
  modport sink   (input valid, input smoothed, input window_median, output ready);
endinterface

// Weight register write channel
interface mtes_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [mtes_pkg::WEIGHT_BITS-1:0]   smoothing_weight;

  modport source (output valid, output smoothing_weight, input ready);
  modport sink   (input valid, input smoothing_weight, output ready);
endinterface

/* hw/rtl/median_then_exponential_smoother_core.sv */
// Channel   Direction  Payload                          Transfer when
// in_if     sink       sample (16b signed)              valid & ready
// out_if    source     smoothed, window_median (16b)    valid & ready
// cfg_if    sink       smoothing_weight (8b)            valid & ready
//
// Steps per item, in order: insert into the sorted cell row, median pick, multiply,
// accumulate. A new sample waits until accumulate is done; the accumulator feeds
// back through the multiply stage. Synchronous active-low reset empties the cell
// row, clears the accumulator and sets the weight to 32. The accumulate step holds
// while the output register is full and not taken; the weight write is always ready.
`include "median_then_exponential_smoother_core_macros.svh"

module median_then_exponential_smoother_core (
  input  logic                clk,
  input  logic                rst_n,
  mtes_sample_if.sink         in_if,
  mtes_result_if.source       out_if,
  mtes_cfg_if.sink            cfg_if
);

  localparam int SB = mtes_pkg::SAMPLE_BITS;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MED  = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_ACC  = 4'b1000
  } state_t;

  state_t                            state_r, state_nxt;
  logic [mtes_pkg::WEIGHT_BITS-1:0]  weight_r;
  logic                              in_fire;
  logic                              out_free;
  logic                              acc_fire;
  logic                              out_valid_r, out_valid_nxt;
  logic signed [SB-1:0]              out_smoothed_r, out_median_r;
  logic signed [SB-1:0]              chain_median;
  logic signed [SB-1:0]              y_nxt;
  logic signed [SB-1:0]              median_q;
  mtes_pkg::smooth_ctrl_t            ctrl;

  assign in_if.ready  = (state_r == ST_IDLE);
  assign in_fire      = in_if.valid && in_if.ready;
  assign out_free     = !out_valid_r || out_if.ready;
  assign acc_fire     = (state_r == ST_ACC) && out_free;
  assign cfg_if.ready = 1'b1;

  // Weight register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= mtes_pkg::WEIGHT_RESET;
    end else if (cfg_if.valid && cfg_if.ready) begin
      weight_r <= cfg_if.smoothing_weight;
    end
  end

  // Sequence one item through the stages
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_MED;
      ST_MED:  state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_ACC;
      ST_ACC:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign ctrl.load_med = (state_r == ST_MED);
  assign ctrl.mul      = (state_r == ST_MUL);
  assign ctrl.acc      = acc_fire;

  mtes_sort_chain u_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (in_fire),
    .sample   (in_if.sample),
    .median   (chain_median)
  );

  mtes_smoother u_smooth (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .median   (chain_median),
    .weight   (weight_r),
    .y_nxt    (y_nxt),
    .median_q (median_q)
  );

  // Output register: load on accumulate, drop on transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (acc_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_fire) begin
      out_smoothed_r <= y_nxt;
      out_median_r   <= median_q;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.smoothed      = out_smoothed_r;
  assign out_if.window_median = out_median_r;

  `MTES_ASSERT_NEXT(a_accept_to_med, in_fire, state_r == ST_MED, "accepted item did not start")
  `MTES_ASSERT_NEXT(a_mul_to_acc, state_r == ST_MUL, state_r == ST_ACC, "multiply stage stalled")
  `MTES_ASSERT_NEXT(a_acc_loads_out, acc_fire, out_valid_r && (state_r == ST_IDLE), "result not presented")
  `MTES_ASSERT_IMP(a_no_accept_busy, state_r != ST_IDLE, !in_if.ready, "accepting while busy")

endmodule

/* hw/rtl/mtes_cell.sv */
module mtes_cell (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    shift_en,
  input  logic                                    full,
  input  logic signed [mtes_pkg::SAMPLE_BITS-1:0] sample,
  input  mtes_pkg::cell_t                         left,
  input  mtes_pkg::cell_t                         right,
  input  logic                                    gone_in,
  output mtes_pkg::cell_t                         state,
  output logic                                    gone_out
);

  mtes_pkg::cell_t state_r, state_nxt;
  mtes_pkg::cell_t r_prev, r_self;
  logic            del_self;
  logic            take_prev;
  logic            take_self;

  // Mark the oldest entry for eviction once the window is full
  assign del_self = full && state_r.valid &&
                    (state_r.age == mtes_pkg::AGE_BITS'(mtes_pkg::WINDOW - 1));
  assign gone_out = gone_in | del_self;

  // Compacted view after eviction: this slot and the one to the left
  assign r_prev = gone_in  ? state_r : left;
  assign r_self = gone_out ? right   : state_r;

  // Insert: shift right if left is larger, keep if ours is not larger, else take sample
  assign take_prev = !r_prev.valid || ($signed(r_prev.value) > $signed(sample));
  assign take_self = r_self.valid && ($signed(r_self.value) <= $signed(sample));

  always_comb begin
    state_nxt = state_r;
    if (shift_en) begin
      if (take_prev) begin
        state_nxt     = r_prev;
        state_nxt.age = r_prev.age + 1'b1;
      end else if (take_self) begin
        state_nxt     = r_self;
        state_nxt.age = r_self.age + 1'b1;
      end else begin
        state_nxt.valid = 1'b1;
        state_nxt.age   = '0;
        state_nxt.value = sample;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mtes_pkg::CELL_EMPTY;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign state = state_r;

endmodule

/* hw/rtl/mtes_sort_chain.sv */
`include "median_then_exponential_smoother_core_macros.svh"

module mtes_sort_chain (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    shift_en,
  input  logic signed [mtes_pkg::SAMPLE_BITS-1:0] sample,
  output logic signed [mtes_pkg::SAMPLE_BITS-1:0] median
);

  localparam int W = mtes_pkg::WINDOW;

  mtes_pkg::cell_t               cells [W];
  mtes_pkg::cell_t               lft   [W];
  mtes_pkg::cell_t               rgt   [W];
  logic [W:0]                    gone;
  logic [W-1:0]                  valid_vec;
  logic [mtes_pkg::CNT_BITS-1:0] fill_r, fill_nxt;
  logic [mtes_pkg::CNT_BITS-1:0] half;
  logic [mtes_pkg::AGE_BITS-1:0] mid_idx;
  logic                          full;

  assign full    = (fill_r == mtes_pkg::CNT_BITS'(W));
  assign gone[0] = 1'b0;

  // Build the row of cells, each wired to its two neighbors
  for (genvar i = 0; i < W; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign lft[i] = mtes_pkg::CELL_LOW_EDGE;
    end else begin : g_inner_l
      assign lft[i] = cells[i-1];
    end
    if (i == W - 1) begin : g_last
      assign rgt[i] = mtes_pkg::CELL_EMPTY;
    end else begin : g_inner_r
      assign rgt[i] = cells[i+1];
    end

    mtes_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .full     (full),
      .sample   (sample),
      .left     (lft[i]),
      .right    (rgt[i]),
      .gone_in  (gone[i]),
      .state    (cells[i]),
      .gone_out (gone[i+1])
    );

    assign valid_vec[i] = cells[i].valid;
  end

  // Count held samples, saturating at the window size
  always_comb begin
    fill_nxt = fill_r;
    if (shift_en && !full) begin
      fill_nxt = fill_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  // Upper middle of the sorted entries
  assign half    = fill_r >> 1;
  assign mid_idx = half[mtes_pkg::AGE_BITS-1:0];
  assign median  = cells[mid_idx].value;

  for (genvar k = 0; k < W - 1; k++) begin : g_chk
    `MTES_ASSERT_IMP(a_sorted, cells[k+1].valid, $signed(cells[k].value) <= $signed(cells[k+1].value), "sort chain out of order")
    `MTES_ASSERT_IMP(a_packed, cells[k+1].valid, cells[k].valid, "sort chain has a hole")
  end
  `MTES_ASSERT_IMP(a_count, 1'b1, $countones(valid_vec) == fill_r, "fill count disagrees with chain")

endmodule

/* hw/rtl/mtes_smoother.sv */
module mtes_smoother (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  mtes_pkg::smooth_ctrl_t                  ctrl,
  input  logic signed [mtes_pkg::SAMPLE_BITS-1:0] median,
  input  logic [mtes_pkg::WEIGHT_BITS-1:0]        weight,
  output logic signed [mtes_pkg::SAMPLE_BITS-1:0] y_nxt,
  output logic signed [mtes_pkg::SAMPLE_BITS-1:0] median_q
);

  localparam int SB = mtes_pkg::SAMPLE_BITS;
  localparam int FB = mtes_pkg::FRAC_BITS;
  localparam int AB = mtes_pkg::ACC_BITS;
  localparam int PB = mtes_pkg::PROD_BITS;

  logic signed [SB-1:0] m_r;
  logic signed [PB-1:0] prod_new_r, prod_old_r;
  logic signed [PB-1:0] prod_new_nxt, prod_old_nxt;
  logic signed [AB-1:0] acc_r, acc_nxt;
  logic                 started_r;
  logic [FB:0]          inv_weight;
  logic signed [SB-1:0] acc_int;
  logic signed [PB-1:0] w_ext, inv_ext, m_ext, q_ext;
  logic signed [PB-1:0] mix_sum;

  // Hold the median for this item
  always_ff @(posedge clk) begin
    if (ctrl.load_med) begin
      m_r <= median;
    end
  end

  // Multiply stage: new median and decayed integer part of the accumulator
  assign inv_weight = (FB + 1)'(mtes_pkg::WEIGHT_ONE) - {1'b0, weight};
  assign acc_int    = acc_r[AB-1:FB];
  assign w_ext      = PB'($signed({1'b0, weight}));
  assign inv_ext    = PB'($signed({1'b0, inv_weight}));
  assign m_ext      = PB'(m_r);
  assign q_ext      = PB'(acc_int);
  assign prod_new_nxt = w_ext * m_ext;
  assign prod_old_nxt = inv_ext * q_ext;

  always_ff @(posedge clk) begin
    if (ctrl.mul) begin
      prod_new_r <= prod_new_nxt;
      prod_old_r <= prod_old_nxt;
    end
  end

  // Accumulate stage: first median loads the accumulator directly
  assign mix_sum = prod_new_r + prod_old_r;

  always_comb begin
    if (started_r) begin
      acc_nxt = mix_sum[AB-1:0];
      y_nxt   = mix_sum[AB-1:FB];
    end else begin
      acc_nxt = {m_r, {FB{1'b0}}};
      y_nxt   = m_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r     <= '0;
      started_r <= 1'b0;
    end else if (ctrl.acc) begin
      acc_r     <= acc_nxt;
      started_r <= 1'b1;
    end
  end

  assign median_q = m_r;

endmodule
